[design/ffaa_pkg.sv]
// shared types, field widths, codes and parameter defaults of the arena allocator
`timescale 1ns / 1ps
`default_nettype none
package ffaa_pkg;

    localparam int KIND_W    = 1;
    localparam int REQ_W     = 21;
    localparam int OFF_W     = 20;
    localparam int STATUS_W  = 2;
    localparam int ARENA_W   = 21;

    localparam int DEF_MAX_CHUNKS      = 64;
    localparam int DEF_HEADER_BYTES    = 32;
    localparam int DEF_ARENA_ADDR_BITS = 20;

    localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOMEM   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNINIT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [REQ_W-1:0]  request_bytes;
        logic [OFF_W-1:0]  release_offset;
    } in_item_t;

    typedef struct packed {
        logic [OFF_W-1:0]    payload_offset;
        logic [STATUS_W-1:0] status;
    } out_item_t;

endpackage
`default_nettype wire

[design/first_fit_arena_allocator_top.sv]
// first-fit arena allocator with split on allocate and coalesce on free
//
//  channel   direction  handshake             payload
//  s_        in         s_valid / s_ready     in_item_t  (kind, request_bytes, release_offset)
//  m_        out        m_valid / m_ready     out_item_t (payload_offset, status)
//  cfg_      in         cfg_we (no wait)      cfg_wdata  (arena_bytes)
//
// one item at a time, s_ready only in idle; every table access goes through the single
// port pair of the chunk table, each entry visited is read, then evaluated or written
// allocate: scan entries, on a split move entries up and write the remainder, then load the result
// free: scan entries, walk back and forward over the free run, merge, compact the
// entries behind it, then load the result
// an uninitialized arena goes straight to loading its result; a result leaves
// through an output register, so the next transfer is taken while that result still waits
// reset is synchronous and needs no clearing pass: the table is rebuilt by every
// arena_bytes write, and entries past the chunk count are never read
`timescale 1ns / 1ps
`default_nettype none
module first_fit_arena_allocator_top
    import ffaa_pkg::*;
#(
    parameter int MAX_CHUNKS      = DEF_MAX_CHUNKS,
    parameter int HEADER_BYTES    = DEF_HEADER_BYTES,
    parameter int ARENA_ADDR_BITS = DEF_ARENA_ADDR_BITS
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire in_item_t           s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output out_item_t               m_data,
    input  wire logic               cfg_we,
    input  wire logic [ARENA_W-1:0] cfg_wdata
);

    // chunk size width, position width, compare width
    localparam int SW   = ARENA_ADDR_BITS;
    localparam int PW   = ARENA_ADDR_BITS + 1;
    localparam int CW   = (PW > REQ_W) ? PW : REQ_W;
    localparam int IW   = $clog2(MAX_CHUNKS);
    localparam int CNTW = $clog2(MAX_CHUNKS + 1);
    localparam int EW   = SW + 1;

    localparam logic [CW-1:0]   HDR_C     = CW'(HEADER_BYTES);
    localparam logic [CNTW-1:0] CNT_MAX   = CNTW'(MAX_CHUNKS);
    localparam logic [CNTW-1:0] CNT_ONE   = CNTW'(1);
    localparam logic [32:0]     ARENA_LIM = 33'(1) << ARENA_ADDR_BITS;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SC_RD = 4'd1;
    localparam logic [3:0] S_SC_EV = 4'd2;
    localparam logic [3:0] S_SH_RD = 4'd3;
    localparam logic [3:0] S_SH_WR = 4'd4;
    localparam logic [3:0] S_SPLIT = 4'd5;
    localparam logic [3:0] S_BK_RD = 4'd6;
    localparam logic [3:0] S_BK_EV = 4'd7;
    localparam logic [3:0] S_FW_RD = 4'd8;
    localparam logic [3:0] S_FW_EV = 4'd9;
    localparam logic [3:0] S_MERGE = 4'd10;
    localparam logic [3:0] S_CP_RD = 4'd11;
    localparam logic [3:0] S_CP_WR = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    logic [3:0]          state_reg, state_next;
    logic [ARENA_W-1:0]  arena_reg, arena_next;
    logic [CNTW-1:0]     count_reg, count_next;
    logic [CNTW-1:0]     idx_reg, idx_next;     // scan index, shift target, walk index
    logic [CNTW-1:0]     s_reg, s_next;         // hit chunk, then start of free run
    logic [CNTW-1:0]     e_reg, e_next;         // end of free run
    logic [PW-1:0]       pos_reg, pos_next;     // header position of the scanned chunk
    logic [SW-1:0]       acc_reg, acc_next;     // split remainder or merged size
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [REQ_W-1:0]    req_reg, req_next;
    logic [OFF_W-1:0]    off_reg, off_next;
    logic [OFF_W-1:0]    res_off_reg, res_off_next;
    logic [STATUS_W-1:0] res_st_reg, res_st_next;
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_data_reg, m_data_next;

    // table port
    logic          ram_we, ram_re;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    logic          r_free;
    logic [SW-1:0] r_size;
    logic [CW-1:0] rest;
    logic [CW-1:0] hdr_pos;
    logic [CNTW-1:0] gap;
    logic [CNTW:0]   cp_src;
    logic [ARENA_W-1:0] cfg_sat;
    logic [CW-1:0]      cfg_size0;

    ffaa_table #(
        .DEPTH (MAX_CHUNKS),
        .WIDTH (EW)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign r_free  = ram_rdata[SW];
    assign r_size  = ram_rdata[SW-1:0];
    assign rest    = CW'(r_size) - CW'(req_reg);
    assign hdr_pos = CW'(pos_reg) + HDR_C;
    assign gap     = e_reg - s_reg;
    assign cp_src  = {1'b0, idx_reg} + {1'b0, gap};

    // oversized arena saturates, a tiny one leaves a zero-size chunk
    assign cfg_sat   = (33'(cfg_wdata) > ARENA_LIM) ? ARENA_LIM[ARENA_W-1:0] : cfg_wdata;
    assign cfg_size0 = (CW'(cfg_sat) > HDR_C) ? (CW'(cfg_sat) - HDR_C) : '0;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        arena_next   = arena_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        s_next       = s_reg;
        e_next       = e_reg;
        pos_next     = pos_reg;
        acc_next     = acc_reg;
        kind_next    = kind_reg;
        req_next     = req_reg;
        off_next     = off_reg;
        res_off_next = res_off_reg;
        res_st_next  = res_st_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    kind_next    = s_data.kind;
                    req_next     = s_data.request_bytes;
                    off_next     = s_data.release_offset;
                    idx_next     = '0;
                    pos_next     = '0;
                    res_off_next = '0;
                    if (arena_reg == '0) begin
                        res_st_next = ST_UNINIT;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_SC_RD;
                    end
                end
            end
            S_SC_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = idx_reg[IW-1:0];
                state_next = S_SC_EV;
            end
            S_SC_EV: begin
                if (kind_reg == KIND_ALLOC && r_free && CW'(r_size) >= CW'(req_reg)) begin
                    ram_we       = 1'b1;
                    ram_waddr    = idx_reg[IW-1:0];
                    res_off_next = hdr_pos[OFF_W-1:0];
                    res_st_next  = ST_OK;
                    s_next       = idx_reg;
                    acc_next     = SW'(rest - HDR_C);
                    if (rest > HDR_C && count_reg < CNT_MAX) begin
                        ram_wdata  = {1'b0, SW'(req_reg)};
                        idx_next   = count_reg;
                        state_next = S_SH_RD;
                    end else begin
                        ram_wdata  = {1'b0, r_size};
                        state_next = S_DONE;
                    end
                end else if (kind_reg == KIND_FREE && hdr_pos == CW'(off_reg)) begin
                    ram_we      = 1'b1;
                    ram_waddr   = idx_reg[IW-1:0];
                    ram_wdata   = {1'b1, r_size};
                    res_st_next = ST_OK;
                    s_next      = idx_reg;
                    state_next  = S_BK_RD;
                end else begin
                    pos_next = PW'(hdr_pos + CW'(r_size));
                    idx_next = idx_reg + CNT_ONE;
                    if (idx_reg + CNT_ONE == count_reg) begin
                        res_st_next = (kind_reg == KIND_ALLOC) ? ST_NOMEM : ST_BADFREE;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_SC_RD;
                    end
                end
            end
            // open a slot after the hit chunk, moving entries up from the tail
            S_SH_RD: begin
                if (idx_reg > s_reg + CNT_ONE) begin
                    ram_re     = 1'b1;
                    ram_raddr  = IW'(idx_reg - CNT_ONE);
                    state_next = S_SH_WR;
                end else begin
                    state_next = S_SPLIT;
                end
            end
            S_SH_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[IW-1:0];
                ram_wdata  = ram_rdata;
                idx_next   = idx_reg - CNT_ONE;
                state_next = S_SH_RD;
            end
            S_SPLIT: begin
                ram_we     = 1'b1;
                ram_waddr  = IW'(s_reg + CNT_ONE);
                ram_wdata  = {1'b1, acc_reg};
                count_next = count_reg + CNT_ONE;
                state_next = S_DONE;
            end
            // walk back to the start of the free run
            S_BK_RD: begin
                if (s_reg == '0) begin
                    idx_next   = s_reg;
                    acc_next   = '0;
                    state_next = S_FW_RD;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = IW'(s_reg - CNT_ONE);
                    state_next = S_BK_EV;
                end
            end
            S_BK_EV: begin
                if (r_free) begin
                    s_next     = s_reg - CNT_ONE;
                    state_next = S_BK_RD;
                end else begin
                    idx_next   = s_reg;
                    acc_next   = '0;
                    state_next = S_FW_RD;
                end
            end
            // walk forward summing the run
            S_FW_RD: begin
                if (idx_reg == count_reg) begin
                    state_next = S_MERGE;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_reg[IW-1:0];
                    state_next = S_FW_EV;
                end
            end
            S_FW_EV: begin
                if (r_free) begin
                    acc_next   = (idx_reg == s_reg) ? r_size
                                                    : SW'(CW'(acc_reg) + HDR_C + CW'(r_size));
                    e_next     = idx_reg;
                    idx_next   = idx_reg + CNT_ONE;
                    state_next = S_FW_RD;
                end else begin
                    state_next = S_MERGE;
                end
            end
            S_MERGE: begin
                ram_we    = 1'b1;
                ram_waddr = s_reg[IW-1:0];
                ram_wdata = {1'b1, acc_reg};
                idx_next  = s_reg + CNT_ONE;
                state_next = (gap == '0) ? S_DONE : S_CP_RD;
            end
            // close the hole left by the merged entries
            S_CP_RD: begin
                if (cp_src >= {1'b0, count_reg}) begin
                    count_next = count_reg - gap;
                    state_next = S_DONE;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = cp_src[IW-1:0];
                    state_next = S_CP_WR;
                end
            end
            S_CP_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[IW-1:0];
                ram_wdata  = ram_rdata;
                idx_next   = idx_reg + CNT_ONE;
                state_next = S_CP_RD;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next               = 1'b1;
                    m_data_next.payload_offset = res_off_reg;
                    m_data_next.status         = res_st_reg;
                    state_next                 = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // arena write rebuilds the table as one free chunk
        if (cfg_we) begin
            arena_next = cfg_sat;
            count_next = CNT_ONE;
            ram_we     = 1'b1;
            ram_waddr  = '0;
            ram_wdata  = {1'b1, SW'(cfg_size0)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            arena_reg   <= '0;
            count_reg   <= CNT_ONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            arena_reg   <= arena_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        s_reg       <= s_next;
        e_reg       <= e_next;
        pos_reg     <= pos_next;
        acc_reg     <= acc_next;
        kind_reg    <= kind_next;
        req_reg     <= req_next;
        off_reg     <= off_next;
        res_off_reg <= res_off_next;
        res_st_reg  <= res_st_next;
        m_data_reg  <= m_data_next;
    end

endmodule
`default_nettype wire

[design/ffaa_table.sv]
// chunk table memory: one write port, one read port with registered read data
`timescale 1ns / 1ps
`default_nettype none
module ffaa_table #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 21
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[design/ffaa_checker.sv]
// port-level checks of the arena allocator and their binding to the top level
`timescale 1ns / 1ps
`default_nettype none
module ffaa_checker
    import ffaa_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire out_item_t          m_data,
    input wire logic               cfg_we
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // busy after taking a transfer
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after a transfer");

    // every failure carries offset zero
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.payload_offset == '0)
        else $error("failure with nonzero offset");

    // arena writes only land on an idle block
    a_cfg_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |-> s_ready && !m_valid)
        else $error("arena written while busy");

endmodule

bind first_fit_arena_allocator_top ffaa_checker u_ffaa_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_we    (cfg_we)
);
`default_nettype wire
